[hw/rtl/msltc_pkg.sv]
// Shared types and request codes for the multi-source LED timeout controller.
`default_nettype none

package msltc_pkg;

  typedef logic [1:0] req_type_t;

  localparam req_type_t REQ_ON   = 2'd0;
  localparam req_type_t REQ_OFF  = 2'd1;
  localparam req_type_t REQ_TICK = 2'd2;

  localparam int LED_IDX_W  = 3;
  localparam int SRC_IDX_W  = 2;
  localparam int HOLD_W     = 16;
  localparam int DRIVE_W    = 8;

endpackage

`default_nettype wire

[hw/rtl/multi_source_led_timeout_controller.sv]
// Multi-source LED timeout controller: per-source hold counters kept in one memory.
// On or off request: the result strobe follows the start transfer through the read, write and result states.
// Tick: the counter memory is swept one entry a cycle through its single read port, then the
// drain and result states lead to the result strobe.
// busy drops in the cycle the result shows, so a new transfer may overlap the strobe.
// Synchronous reset clears control, active bits and counter valid bits at once; no sweep.
`default_nettype none

module multi_source_led_timeout_controller #(
  parameter int LED_COUNT    = 8,
  parameter int SOURCE_COUNT = 4,
  parameter int TIME_BITS    = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire msltc_pkg::req_type_t              req_type,
  input  wire logic [msltc_pkg::LED_IDX_W-1:0]   led_index,
  input  wire logic [msltc_pkg::SRC_IDX_W-1:0]   source_index,
  input  wire logic [msltc_pkg::HOLD_W-1:0]      hold_time,
  output logic                                   done,
  output logic [msltc_pkg::DRIVE_W-1:0]          led_drive
);

  localparam int ENTRIES = LED_COUNT * SOURCE_COUNT;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LED_W   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int SRC_W   = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
  localparam int EXT_W   = (TIME_BITS > msltc_pkg::HOLD_W) ? TIME_BITS : msltc_pkg::HOLD_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [LED_W-1:0]     LED_LAST = LED_W'(LED_COUNT - 1);
  localparam logic [SRC_W-1:0]     SRC_LAST = SRC_W'(SOURCE_COUNT - 1);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_REQ_RD     = 3'd1;
  localparam logic [2:0] S_REQ_WR     = 3'd2;
  localparam logic [2:0] S_TICK_RD    = 3'd3;
  localparam logic [2:0] S_TICK_DRAIN = 3'd4;
  localparam logic [2:0] S_RESULT     = 3'd5;

  logic [2:0] state;

  // latched request
  logic                 req_on;
  logic [LED_W-1:0]     req_led;
  logic [SRC_W-1:0]     req_src;
  logic [TIME_BITS-1:0] req_time;
  logic [ADDR_W-1:0]    req_addr;

  // tick sweep issue side
  logic [LED_W-1:0]  tk_led;
  logic [SRC_W-1:0]  tk_src;
  logic [ADDR_W-1:0] tk_addr;
  logic              tk_last;

  // tick sweep writeback side
  logic              wb_en;
  logic [LED_W-1:0]  wb_led;
  logic [SRC_W-1:0]  wb_src;
  logic [ADDR_W-1:0] wb_addr;

  // counter memory
  logic [TIME_BITS-1:0] cnt_mem [ENTRIES];
  logic [ENTRIES-1:0]   cnt_valid;
  logic [ADDR_W-1:0]    rd_addr;
  logic [TIME_BITS-1:0] mem_q;
  logic                 rd_valid;
  logic [TIME_BITS-1:0] old_cnt;

  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [TIME_BITS-1:0] wr_data;

  logic [SOURCE_COUNT-1:0] active [LED_COUNT];

  logic                 accept;
  logic                 in_valid;
  logic [EXT_W-1:0]     hold_ext;
  logic [TIME_BITS-1:0] hold_sat;
  logic [LED_W-1:0]     in_led;
  logic [SRC_W-1:0]     in_src;
  logic [msltc_pkg::DRIVE_W-1:0] drive_now;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign in_valid = (32'(led_index) < LED_COUNT) && (32'(source_index) < SOURCE_COUNT);
  assign in_led  = LED_W'(led_index);
  assign in_src  = SRC_W'(source_index);
  assign hold_ext = EXT_W'(hold_time);
  assign hold_sat = (hold_ext > EXT_W'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(hold_ext);
  assign tk_last = (tk_led == LED_LAST) && (tk_src == SRC_LAST);
  assign rd_addr = (state == S_TICK_RD) ? tk_addr : req_addr;
  assign old_cnt = rd_valid ? mem_q : '0;

  // single write port: tick writeback or request writeback
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = req_addr;
    wr_data = '0;
    if (wb_en) begin
      wr_en   = (old_cnt != '0);
      wr_addr = wb_addr;
      wr_data = old_cnt - TIME_BITS'(1);
    end else if (state == S_REQ_WR) begin
      wr_en   = 1'b1;
      wr_addr = req_addr;
      wr_data = (req_on && (req_time > old_cnt)) ? req_time :
                (req_on ? old_cnt : '0);
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= cnt_mem[rd_addr];
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= cnt_valid[rd_addr];
      if (wr_en) begin
        cnt_valid[wr_addr] <= 1'b1;
      end
    end
  end

  // active source bits; an LED is lit exactly when one of its sources is active
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LED_COUNT; l++) begin
        active[l] <= '0;
      end
    end else if (wb_en) begin
      if (old_cnt == '0) begin
        active[wb_led][wb_src] <= 1'b0;
      end
    end else if (state == S_REQ_WR) begin
      active[req_led][req_src] <= req_on;
    end
  end

  generate
    for (genvar g = 0; g < msltc_pkg::DRIVE_W; g++) begin : g_drive
      if (g < LED_COUNT) begin : g_led
        assign drive_now[g] = |active[g];
      end else begin : g_none
        assign drive_now[g] = 1'b0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (accept) begin
      req_on   <= (req_type == msltc_pkg::REQ_ON);
      req_led  <= in_led;
      req_src  <= in_src;
      req_time <= hold_sat;
      req_addr <= ADDR_W'(32'(in_led) * SOURCE_COUNT + 32'(in_src));
    end
    if (state == S_TICK_RD) begin
      wb_led  <= tk_led;
      wb_src  <= tk_src;
      wb_addr <= tk_addr;
    end
    if (state == S_RESULT) begin
      led_drive <= drive_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      wb_en   <= 1'b0;
      tk_led  <= '0;
      tk_src  <= '0;
      tk_addr <= '0;
    end else begin
      done  <= (state == S_RESULT);
      wb_en <= (state == S_TICK_RD);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            tk_led  <= '0;
            tk_src  <= '0;
            tk_addr <= '0;
            if (req_type == msltc_pkg::REQ_TICK) begin
              state <= S_TICK_RD;
            end else if (in_valid && (req_type == msltc_pkg::REQ_ON ||
                                      req_type == msltc_pkg::REQ_OFF)) begin
              state <= S_REQ_RD;
            end else begin
              state <= S_RESULT;
            end
          end
        end
        S_REQ_RD:  state <= S_REQ_WR;
        S_REQ_WR:  state <= S_RESULT;
        S_TICK_RD: begin
          // advance the sweep one entry a cycle
          tk_addr <= tk_addr + ADDR_W'(1);
          if (tk_src == SRC_LAST) begin
            tk_src <= '0;
            tk_led <= tk_led + LED_W'(1);
          end else begin
            tk_src <= tk_src + SRC_W'(1);
          end
          if (tk_last) begin
            state <= S_TICK_DRAIN;
          end
        end
        S_TICK_DRAIN: state <= S_RESULT;
        S_RESULT:     state <= S_IDLE;
        default:      state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sim/multi_source_led_timeout_controller_test.sv]
// Self-checking testbench for the multi-source LED timeout controller.
`default_nettype none

module multi_source_led_timeout_controller_test;

  localparam int LED_IDX_W  = msltc_pkg::LED_IDX_W;
  localparam int SRC_IDX_W  = msltc_pkg::SRC_IDX_W;
  localparam int HOLD_W     = msltc_pkg::HOLD_W;
  localparam int DRIVE_W    = msltc_pkg::DRIVE_W;

  localparam int LEDS       = 8;
  localparam int SOURCES    = 4;
  localparam int SWEEP_LAT  = LEDS * SOURCES + 3;
  localparam int RAND_ITEMS = 1550;
  localparam int CYCLE_LIMIT = 800000;
  localparam msltc_pkg::req_type_t REQ_UNUSED = 2'd3;

  typedef struct packed {
    msltc_pkg::req_type_t req;
    logic [LED_IDX_W-1:0] led;
    logic [SRC_IDX_W-1:0] src;
    logic [HOLD_W-1:0]    hold;
    logic                 typed;
    logic [DRIVE_W-1:0]   want;
  } stim_row_t;

  localparam int DIR_ROWS = 21;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  msltc_pkg::req_type_t req_type = msltc_pkg::REQ_ON;
  logic [LED_IDX_W-1:0] led_index = '0;
  logic [SRC_IDX_W-1:0] source_index = '0;
  logic [HOLD_W-1:0]    hold_time = '0;
  logic                 done;
  logic [DRIVE_W-1:0]   led_drive;

  // Typed expectation that rides along with the current directed request.
  logic                 row_typed = 1'b0;
  logic [DRIVE_W-1:0]   row_want = '0;

  // Shadow copy of the controller state.
  logic [SOURCES-1:0]   src_active [LEDS];
  logic [HOLD_W-1:0]    hold_left [LEDS][SOURCES];
  logic [LEDS-1:0]      led_on;

  logic [DRIVE_W-1:0]   drive_expected [$];
  int                   error_count = 0;
  int                   results_checked = 0;
  int                   requests_sent = 0;
  int                   ticks_sent = 0;
  int                   cycle_count = 0;

  stim_row_t directed_rows [DIR_ROWS] = '{
    '{msltc_pkg::REQ_TICK, 3'd0, 2'd0, 16'h0000, 1'b1, 8'h00},
    '{REQ_UNUSED,          3'd0, 2'd0, 16'h0000, 1'b1, 8'h00},
    '{msltc_pkg::REQ_OFF,  3'd0, 2'd0, 16'h0000, 1'b1, 8'h00},
    '{msltc_pkg::REQ_ON,   3'd7, 2'd3, 16'hFFFF, 1'b1, 8'h80},
    '{msltc_pkg::REQ_ON,   3'd0, 2'd0, 16'h0000, 1'b1, 8'h81},
    '{msltc_pkg::REQ_TICK, 3'd0, 2'd0, 16'h0000, 1'b1, 8'h80},
    '{msltc_pkg::REQ_ON,   3'd3, 2'd1, 16'h0001, 1'b1, 8'h88},
    '{msltc_pkg::REQ_TICK, 3'd0, 2'd0, 16'h0000, 1'b1, 8'h88},
    '{msltc_pkg::REQ_TICK, 3'd0, 2'd0, 16'h0000, 1'b1, 8'h80},
    '{msltc_pkg::REQ_ON,   3'd5, 2'd0, 16'h0002, 1'b1, 8'hA0},
    '{msltc_pkg::REQ_ON,   3'd5, 2'd2, 16'h000A, 1'b1, 8'hA0},
    '{msltc_pkg::REQ_OFF,  3'd5, 2'd0, 16'h0000, 1'b1, 8'hA0},
    '{msltc_pkg::REQ_OFF,  3'd5, 2'd2, 16'h0000, 1'b1, 8'h80},
    '{msltc_pkg::REQ_ON,   3'd2, 2'd1, 16'h0005, 1'b0, 8'h00},
    '{msltc_pkg::REQ_ON,   3'd2, 2'd1, 16'h0003, 1'b0, 8'h00},
    '{REQ_UNUSED,          3'd7, 2'd3, 16'hFFFF, 1'b1, 8'h84},
    '{msltc_pkg::REQ_OFF,  3'd7, 2'd3, 16'hFFFF, 1'b1, 8'h04},
    '{msltc_pkg::REQ_ON,   3'd1, 2'd0, 16'h5555, 1'b0, 8'h00},
    '{msltc_pkg::REQ_ON,   3'd6, 2'd2, 16'hAAAA, 1'b0, 8'h00},
    '{msltc_pkg::REQ_TICK, 3'd7, 2'd3, 16'hFFFF, 1'b0, 8'h00},
    '{msltc_pkg::REQ_OFF,  3'd2, 2'd1, 16'h0000, 1'b0, 8'h00}
  };

  multi_source_led_timeout_controller dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .led_index    (led_index),
    .source_index (source_index),
    .hold_time    (hold_time),
    .done         (done),
    .led_drive    (led_drive)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [DRIVE_W-1:0] got,
                                 input logic [DRIVE_W-1:0] want);
    $display("mismatch at cycle %0d: %s, led_drive got %02h want %02h",
             cycle_count, what, got, want);
    error_count++;
  endtask

  // Apply one request to the shadow state and return the LED drive vector after it.
  function automatic logic [DRIVE_W-1:0] next_led_drive(input msltc_pkg::req_type_t req,
      input logic [LED_IDX_W-1:0] led, input logic [SRC_IDX_W-1:0] src,
      input logic [HOLD_W-1:0] hold);
    case (req)
      msltc_pkg::REQ_ON: begin
        src_active[led][src] = 1'b1;
        led_on[led] = 1'b1;
        if (hold > hold_left[led][src]) hold_left[led][src] = hold;
      end
      msltc_pkg::REQ_OFF: begin
        src_active[led][src] = 1'b0;
        hold_left[led][src] = '0;
        if (src_active[led] == '0) led_on[led] = 1'b0;
      end
      msltc_pkg::REQ_TICK: begin
        for (int l = 0; l < LEDS; l++) begin
          for (int s = 0; s < SOURCES; s++) begin
            if (hold_left[l][s] != '0) hold_left[l][s] = hold_left[l][s] - 1'b1;
            else src_active[l][s] = 1'b0;
          end
          if (src_active[l] == '0) led_on[l] = 1'b0;
        end
      end
      default: ;
    endcase
    return led_on[DRIVE_W-1:0];
  endfunction

  // Check results first, then queue the expectation of a transfer at the same edge.
  always @(posedge clk) begin
    logic [DRIVE_W-1:0] predicted;
    if (!rst) begin
      if (done) begin
        if (drive_expected.size() == 0) begin
          report_mismatch("result with nothing pending", led_drive, '0);
        end else begin
          if (led_drive !== drive_expected[0])
            report_mismatch("wrong drive vector", led_drive, drive_expected[0]);
          void'(drive_expected.pop_front());
          results_checked++;
        end
      end
      if (start && !busy) begin
        predicted = next_led_drive(req_type, led_index, source_index, hold_time);
        drive_expected.push_back(row_typed ? row_want : predicted);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, drive_expected.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one request at the falling edge and hold it until the transfer.
  task automatic send_request(input msltc_pkg::req_type_t req,
                              input logic [LED_IDX_W-1:0] led,
                              input logic [SRC_IDX_W-1:0] src,
                              input logic [HOLD_W-1:0] hold, input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    req_type = req;
    led_index = led;
    source_index = src;
    hold_time = hold;
    do @(posedge clk); while (busy);
    requests_sent++;
    if (req == msltc_pkg::REQ_TICK) ticks_sent++;
    @(negedge clk);
  endtask

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 45);
  endfunction

  function automatic logic [HOLD_W-1:0] pick_hold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return HOLD_W'($urandom_range(0, 6));
    if (r < 90) return HOLD_W'($urandom_range(0, 65535));
    return (r < 95) ? '0 : '1;
  endfunction

  initial begin
    msltc_pkg::req_type_t req;
    bit        quiet;
    int        r;
    for (int l = 0; l < LEDS; l++) begin
      src_active[l] = '0;
      for (int s = 0; s < SOURCES; s++) hold_left[l][s] = '0;
    end
    led_on = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      row_typed = directed_rows[i].typed;
      row_want = directed_rows[i].want;
      send_request(directed_rows[i].req, directed_rows[i].led, directed_rows[i].src,
                   directed_rows[i].hold, (i % 3 == 2) ? 2 : 0);
    end
    row_typed = 1'b0;

    quiet = 1'b0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      // Alternate stretches with and without idle cycles between transfers.
      if (i % 120 == 0) quiet = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) req = msltc_pkg::REQ_ON;
      else if (r < 70) req = msltc_pkg::REQ_OFF;
      else if (r < 95) req = msltc_pkg::REQ_TICK;
      else req = REQ_UNUSED;
      send_request(req, LED_IDX_W'($urandom_range(0, 7)), SRC_IDX_W'($urandom_range(0, 3)),
                   pick_hold(), pick_gap(quiet));
    end
    start = 1'b0;

    while (drive_expected.size() != 0) @(posedge clk);
    repeat (SWEEP_LAT + 10) @(posedge clk);

    $display("%0d requests (%0d ticks) sent, %0d drive vectors checked, %0d mismatches",
             requests_sent, ticks_sent, results_checked, error_count);
    if (error_count == 0 && drive_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hw/rtl/msltc_pkg.sv
hw/rtl/multi_source_led_timeout_controller.sv
sim/multi_source_led_timeout_controller_test.sv
